/* design/ncl1_pkg.sv */
package ncl1_pkg;

	localparam int MAX_ENTRIES    = 16;
	localparam int MAX_FEATURES   = 8;
	localparam int VALUE_BITS     = 30;
	localparam int ENTRY_BITS     = $clog2(MAX_ENTRIES);
	localparam int ENTRY_CNT_BITS = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_CFG_BITS = 5;
	localparam int FEAT_CFG_BITS  = 4;
	localparam int CFG_DATA_BITS  = 5;
	localparam int SYMBOL_BITS    = 8;
	localparam int SUM_BITS       = VALUE_BITS + 3;

	// stream packing
	localparam int IN_INDEX_LSB   = 0;
	localparam int IN_SYMBOL_LSB  = IN_INDEX_LSB + ENTRY_BITS;
	localparam int IN_FEAT_LSB    = IN_SYMBOL_LSB + SYMBOL_BITS;
	localparam int IN_DATA_BITS   = 256;
	localparam int OUT_DATA_BITS  = 48;
	localparam int OUT_PAD_BITS   = OUT_DATA_BITS - SUM_BITS - SYMBOL_BITS - ENTRY_BITS;

	typedef enum logic [0:0] {
		REG_ENTRIES_IN_USE  = 1'b0,
		REG_FEATURES_IN_USE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD     = 1'b0,
		KIND_CLASSIFY = 1'b1
	} kind_t;

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic                   valid;
		logic                   last;
		logic [ENTRY_BITS-1:0]  index;
		logic [SYMBOL_BITS-1:0] symbol;
	} tag_t;

	typedef struct packed {
		logic                   found;
		logic [ENTRY_BITS-1:0]  index;
		logic [SYMBOL_BITS-1:0] symbol;
		logic [SUM_BITS-1:0]    sum;
	} best_t;

endpackage

/* design/nearest_codeword_l1_classifier_unit.sv */
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | tuser=kind, tdata=entry_index,entry_symbol,feature_0..7
// m_*      | out | m_tvalid/m_tready  | tuser=found, tdata=best_index,best_symbol,distance_sum
// cfg_*    | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// A load item writes all eight lane RAMs and the symbol RAM.
// A classify item reads one codebook entry per cycle into eight lanes, then a three-level
// adder tree and the running-minimum compare; the result moves to the output register and
// s_tready rises with m_tvalid, so no new item is taken while a search runs.
// An empty codebook skips the search and goes straight to posting a result with found clear.
// Reset sets entries_in_use to 0 and features_in_use to 8; RAMs are not cleared.
// A result waiting on m_tready holds in the output register while the next item is taken.
module nearest_codeword_l1_classifier_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ncl1_pkg::IN_DATA_BITS-1:0]     s_tdata,  // entry_index, entry_symbol, feature_0..7, pad
	input  logic                                  s_tuser,  // kind
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [ncl1_pkg::OUT_DATA_BITS-1:0]    m_tdata,  // best_index, best_symbol, distance_sum, pad
	output logic                                  m_tuser,  // found
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_index,
	input  logic [ncl1_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import ncl1_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [ENTRY_CFG_BITS-1:0] entries_q;
	logic [FEAT_CFG_BITS-1:0]  features_q;
	logic [ENTRY_CNT_BITS-1:0] cnt_q;
	logic [ENTRY_CNT_BITS-1:0] ne_sat;
	logic [FEAT_CFG_BITS-1:0]  nf_sat;
	value_t                    snap_q [MAX_FEATURES];
	value_t                    feat_in [MAX_FEATURES];
	value_t                    diff_s2 [MAX_FEATURES];
	logic [ENTRY_BITS-1:0]     in_index;
	logic [SYMBOL_BITS-1:0]    in_symbol;
	logic [SYMBOL_BITS-1:0]    sym_rd;
	logic                      accept;
	logic                      load_we;
	logic                      start;
	logic [ENTRY_BITS-1:0]     raddr;
	tag_t                      tag_q;
	tag_t                      tag_s1;
	best_t                     best;
	logic                      merge_done;
	best_t                     out_q;
	logic                      out_valid_q;
	logic                      out_free;

	assign accept    = s_tvalid && s_tready;
	assign in_index  = s_tdata[IN_INDEX_LSB +: ENTRY_BITS];
	assign in_symbol = s_tdata[IN_SYMBOL_LSB +: SYMBOL_BITS];
	assign load_we   = accept && (s_tuser == KIND_LOAD) &&
	                   ({1'b0, in_index} < ENTRY_CNT_BITS'(MAX_ENTRIES));
	assign start     = accept && (s_tuser == KIND_CLASSIFY);

	assign ne_sat = (entries_q > ENTRY_CFG_BITS'(MAX_ENTRIES)) ?
	                ENTRY_CNT_BITS'(MAX_ENTRIES) : ENTRY_CNT_BITS'(entries_q);
	assign nf_sat = (features_q > FEAT_CFG_BITS'(MAX_FEATURES)) ?
	                FEAT_CFG_BITS'(MAX_FEATURES) : features_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= '0;
			features_q <= FEAT_CFG_BITS'(MAX_FEATURES);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRIES_IN_USE:  entries_q  <= cfg_data[ENTRY_CFG_BITS-1:0];
				REG_FEATURES_IN_USE: features_q <= cfg_data[FEAT_CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= (ne_sat == '0) ? ST_DONE : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + ENTRY_CNT_BITS'(1);
					if (cnt_q == ne_sat - ENTRY_CNT_BITS'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (merge_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q.valid  <= (state_q == ST_ISSUE);
			tag_q.last   <= (cnt_q == ne_sat - ENTRY_CNT_BITS'(1));
			tag_q.index  <= cnt_q[ENTRY_BITS-1:0];
			tag_q.symbol <= '0;
		end
	end

	always_comb begin
		tag_s1        = tag_q;
		tag_s1.symbol = sym_rd;
	end

	assign raddr = cnt_q[ENTRY_BITS-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			snap_q <= feat_in;
		end
	end

	ncl1_ram #(
		.WIDTH(SYMBOL_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_sym_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(in_index),
		.wdata(in_symbol),
		.raddr(raddr),
		.rdata(sym_rd)
	);

	for (genvar f = 0; f < MAX_FEATURES; f++) begin : g_lane
		assign feat_in[f] = s_tdata[IN_FEAT_LSB + f*VALUE_BITS +: VALUE_BITS];

		ncl1_lane u_lane (
			.clk    (clk),
			.we     (load_we),
			.waddr  (in_index),
			.wdata  (feat_in[f]),
			.raddr  (raddr),
			.snap   (snap_q[f]),
			.lane_on(FEAT_CFG_BITS'(f) < nf_sat),
			.diff_s2(diff_s2[f])
		);
	end

	ncl1_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (start),
		.tag_s1 (tag_s1),
		.diff_s2(diff_s2),
		.best   (best),
		.done   (merge_done)
	);

	// output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= best;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.found;
	assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_q.sum, out_q.symbol, out_q.index};

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (cnt_q < ne_sat))
		else $error("read issued past last entry in use");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		merge_done |-> (state_q == ST_DRAIN))
		else $error("search finished outside drain");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> m_tvalid && (state_q == ST_IDLE))
		else $error("finished result not posted");

endmodule

/* design/ncl1_ram.sv */
module ncl1_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/ncl1_lane.sv */
module ncl1_lane (
	input  logic                               clk,
	input  logic                               we,
	input  logic [ncl1_pkg::ENTRY_BITS-1:0]    waddr,
	input  ncl1_pkg::value_t                   wdata,
	input  logic [ncl1_pkg::ENTRY_BITS-1:0]    raddr,
	input  ncl1_pkg::value_t                   snap,
	input  logic                               lane_on,
	output ncl1_pkg::value_t                   diff_s2
);
	import ncl1_pkg::*;

	value_t rd_s1;
	value_t diff_q;

	ncl1_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_s1)
	);

	// lanes beyond features_in_use contribute nothing
	always_ff @(posedge clk) begin
		if (!lane_on) begin
			diff_q <= '0;
		end else if (snap >= rd_s1) begin
			diff_q <= snap - rd_s1;
		end else begin
			diff_q <= rd_s1 - snap;
		end
	end

	assign diff_s2 = diff_q;

endmodule

/* design/ncl1_merge.sv */
module ncl1_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  ncl1_pkg::tag_t   tag_s1,
	input  ncl1_pkg::value_t diff_s2 [ncl1_pkg::MAX_FEATURES],
	output ncl1_pkg::best_t  best,
	output logic             done
);
	import ncl1_pkg::*;

	tag_t tag_s2, tag_s3, tag_s4, tag_s5;
	logic [VALUE_BITS:0]   sum_s3 [4];
	logic [VALUE_BITS+1:0] sum_s4 [2];
	logic [SUM_BITS-1:0]   sum_s5;
	best_t best_q;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// registered adder tree, one level per stage
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sum_s3[i] <= {1'b0, diff_s2[2*i]} + {1'b0, diff_s2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			sum_s4[i] <= {1'b0, sum_s3[2*i]} + {1'b0, sum_s3[2*i+1]};
		end
		sum_s5 <= {1'b0, sum_s4[0]} + {1'b0, sum_s4[1]};
	end

	// strict compare keeps the earliest entry on a tie
	assign take = tag_s5.valid && (!best_q.found || (sum_s5 < best_q.sum));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clear) begin
			best_q <= '0;
		end else if (take) begin
			best_q.found  <= 1'b1;
			best_q.index  <= tag_s5.index;
			best_q.symbol <= tag_s5.symbol;
			best_q.sum    <= sum_s5;
		end
	end

	assign best = best_q;
	assign done = tag_s5.valid && tag_s5.last;

	a_found_after_entry: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s5.valid && !clear |=> best_q.found)
		else $error("entry compared but nothing recorded");

	a_first_entry_taken: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s5.valid && !best_q.found && !clear |=> best_q.index == $past(tag_s5.index))
		else $error("first compared entry not taken");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import ncl1_pkg::*;

	localparam int    QUIET_LIMIT = 3000;
	localparam int    HOLD_CYCLES = 400;
	localparam int    SETTLE      = 40;
	localparam int    EXP_DEPTH   = 16;
	localparam value_t VALUE_MAX  = '1;

	typedef value_t feat_vec_t [MAX_FEATURES];

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic                     s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tuser;
	logic                     cfg_we;
	logic [0:0]               cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// local copy of the codebook and the two registers
	value_t                 book_vals [MAX_ENTRIES][MAX_FEATURES];
	logic [SYMBOL_BITS-1:0] book_syms [MAX_ENTRIES];
	logic [ENTRY_CFG_BITS-1:0] cur_entries;
	logic [FEAT_CFG_BITS-1:0]  cur_features;

	// expected results in order, written at the accepting edge
	best_t      expected [EXP_DEPTH];
	logic [3:0] exp_wr_ptr = '0;
	logic [3:0] exp_rd_ptr = '0;
	int    error_count = 0;
	int    quiet_cycles = 0;
	bit    calm = 1'b0;
	bit    hold_request = 1'b0;

	nearest_codeword_l1_classifier_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic best_t nearest_codeword(input feat_vec_t snap);
		best_t               r;
		int                  ne;
		int                  nf;
		logic [SUM_BITS-1:0] acc;
		value_t              d;
		r = '0;
		ne = (cur_entries > MAX_ENTRIES) ? MAX_ENTRIES : int'(cur_entries);
		nf = (cur_features > MAX_FEATURES) ? MAX_FEATURES : int'(cur_features);
		for (int e = 0; e < ne; e++) begin
			acc = '0;
			for (int f = 0; f < nf; f++) begin
				d = (snap[f] >= book_vals[e][f]) ? snap[f] - book_vals[e][f]
				                                 : book_vals[e][f] - snap[f];
				acc += SUM_BITS'(d);
			end
			// strict compare keeps the lower index on a tie
			if (!r.found || acc < r.sum) begin
				r.found  = 1'b1;
				r.index  = ENTRY_BITS'(e);
				r.symbol = book_syms[e];
				r.sum    = acc;
			end
		end
		return r;
	endfunction

	function automatic value_t nudge(input value_t base);
		longint span;
		longint v;
		case ($urandom_range(3))
			0:       span = 0;
			1:       span = 15;
			2:       span = 4095;
			default: span = longint'(1) << 29;
		endcase
		if ($urandom_range(1))
			v = longint'(base) + longint'($urandom_range(32'(span)));
		else
			v = longint'(base) - longint'($urandom_range(32'(span)));
		if (v < 0)
			v = 0;
		if (v > longint'(VALUE_MAX))
			v = longint'(VALUE_MAX);
		return value_t'(v);
	endfunction

	function automatic value_t rand_value();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return VALUE_MAX;
		return value_t'($urandom);
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
	                             input logic [63:0] want);
		error_count++;
		if (error_count <= 100)
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	// one item on the slave side; prediction happens at the accepting edge
	task automatic send_item(input kind_t kind, input logic [ENTRY_BITS-1:0] idx,
	                         input logic [SYMBOL_BITS-1:0] sym, input feat_vec_t feat);
		logic [IN_DATA_BITS-1:0] w;
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		w = '0;
		w[IN_INDEX_LSB +: ENTRY_BITS]   = idx;
		w[IN_SYMBOL_LSB +: SYMBOL_BITS] = sym;
		for (int f = 0; f < MAX_FEATURES; f++)
			w[IN_FEAT_LSB + f*VALUE_BITS +: VALUE_BITS] = feat[f];
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind == KIND_LOAD) begin
			for (int f = 0; f < MAX_FEATURES; f++)
				book_vals[idx][f] = feat[f];
			book_syms[idx] = sym;
		end else begin
			expected[exp_wr_ptr] = nearest_codeword(feat);
			exp_wr_ptr = exp_wr_ptr + 4'd1;
		end
	endtask

	task automatic classify(input feat_vec_t feat);
		send_item(KIND_CLASSIFY, ENTRY_BITS'($urandom), SYMBOL_BITS'($urandom), feat);
	endtask

	// block goes quiet: every result in, then room for a trailing load
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_wr_ptr != exp_rd_ptr)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_settings(input int entries, input int features);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ENTRIES_IN_USE;
		cfg_data  <= CFG_DATA_BITS'(entries);
		@(posedge clk);
		cur_entries = ENTRY_CFG_BITS'(entries);
		cfg_index <= REG_FEATURES_IN_USE;
		cfg_data  <= CFG_DATA_BITS'(features);
		@(posedge clk);
		cur_features = FEAT_CFG_BITS'(features);
		cfg_we <= 1'b0;
	endtask

	task automatic vec_fill(output feat_vec_t v, input value_t val);
		for (int f = 0; f < MAX_FEATURES; f++)
			v[f] = val;
	endtask

	task automatic vec_random(output feat_vec_t v);
		for (int f = 0; f < MAX_FEATURES; f++)
			v[f] = rand_value();
	endtask

	task automatic vec_near(output feat_vec_t v, input int e);
		for (int f = 0; f < MAX_FEATURES; f++)
			v[f] = nudge(book_vals[e][f]);
	endtask

	task automatic test_empty_codebook();
		feat_vec_t v;
		vec_random(v);
		classify(v);
	endtask

	// every entry gets written here, so no later search reads an unwritten one
	task automatic test_codebook_fill();
		feat_vec_t v;
		feat_vec_t twin;
		vec_fill(v, '0);
		send_item(KIND_LOAD, ENTRY_BITS'(0), 8'h00, v);
		vec_fill(v, VALUE_MAX);
		send_item(KIND_LOAD, ENTRY_BITS'(1), 8'hff, v);
		vec_random(twin);
		send_item(KIND_LOAD, ENTRY_BITS'(2), 8'h5a, twin);
		send_item(KIND_LOAD, ENTRY_BITS'(3), 8'ha5, twin);
		for (int e = 4; e < MAX_ENTRIES; e++) begin
			vec_random(v);
			send_item(KIND_LOAD, ENTRY_BITS'(e), SYMBOL_BITS'($urandom), v);
		end
	endtask

	task automatic test_extremes();
		feat_vec_t v;
		// only the all-zero entry searched: largest possible distance
		write_settings(1, 8);
		vec_fill(v, VALUE_MAX);
		classify(v);
		write_settings(16, 8);
		classify(v);
		vec_fill(v, '0);
		classify(v);
		// entries 2 and 3 hold the same codeword; the lower one must win
		for (int f = 0; f < MAX_FEATURES; f++)
			v[f] = book_vals[2][f];
		classify(v);
	endtask

	task automatic test_saturation();
		feat_vec_t v;
		write_settings(31, 15);
		vec_random(v);
		classify(v);
		write_settings(16, 0);
		vec_random(v);
		classify(v);
		write_settings(20, 1);
		vec_near(v, $urandom_range(MAX_ENTRIES - 1));
		classify(v);
	endtask

	task automatic run_random_phase(input int n_items);
		feat_vec_t v;
		int        r;
		int        span;
		int        src;
		span = (cur_entries == 0) ? MAX_ENTRIES
		     : (cur_entries > MAX_ENTRIES) ? MAX_ENTRIES : int'(cur_entries);
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 15) begin
				src = $urandom_range(MAX_ENTRIES - 1);
				case ($urandom_range(2))
					0:       for (int f = 0; f < MAX_FEATURES; f++) v[f] = book_vals[src][f];
					1:       vec_near(v, src);
					default: vec_random(v);
				endcase
				send_item(KIND_LOAD, ENTRY_BITS'($urandom), SYMBOL_BITS'($urandom), v);
			end else if (r < 27) begin
				vec_random(v);
				classify(v);
			end else begin
				vec_near(v, $urandom_range(span - 1));
				classify(v);
			end
		end
	endtask

	task automatic test_random();
		int ent_tab  [10] = '{16, 1, 31, 0, 16, 5, 17, 12, 16, 2};
		int feat_tab [10] = '{8, 1, 15, 0, 3, 8, 4, 9, 2, 7};
		for (int p = 0; p < 10; p++) begin
			write_settings(ent_tab[p], feat_tab[p]);
			calm = (p == 4);
			run_random_phase(75);
		end
		calm = 1'b0;
	endtask

	// receiver stalls long enough for the block to back up into s_tready
	task automatic test_backpressure();
		feat_vec_t v;
		write_settings(16, 8);
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++) begin
			vec_near(v, $urandom_range(MAX_ENTRIES - 1));
			classify(v);
		end
	endtask

	// receiver
	initial begin
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 12);
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		best_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_wr_ptr == exp_rd_ptr) begin
				note_mismatch("result with nothing expected", 64'(m_tdata), 64'(0));
			end else begin
				want = expected[exp_rd_ptr];
				exp_rd_ptr = exp_rd_ptr + 4'd1;
				if (m_tuser !== want.found)
					note_mismatch("found", 64'(m_tuser), 64'(want.found));
				if (m_tdata[0 +: ENTRY_BITS] !== want.index)
					note_mismatch("best_index", 64'(m_tdata[0 +: ENTRY_BITS]),
					              64'(want.index));
				if (m_tdata[ENTRY_BITS +: SYMBOL_BITS] !== want.symbol)
					note_mismatch("best_symbol", 64'(m_tdata[ENTRY_BITS +: SYMBOL_BITS]),
					              64'(want.symbol));
				if (m_tdata[ENTRY_BITS + SYMBOL_BITS +: SUM_BITS] !== want.sum)
					note_mismatch("distance_sum",
					              64'(m_tdata[ENTRY_BITS + SYMBOL_BITS +: SUM_BITS]),
					              64'(want.sum));
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = KIND_LOAD;
		cfg_we    = 1'b0;
		cfg_index = REG_ENTRIES_IN_USE;
		cfg_data  = '0;
		cur_entries  = '0;
		cur_features = FEAT_CFG_BITS'(MAX_FEATURES);
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			book_syms[e] = '0;
			for (int f = 0; f < MAX_FEATURES; f++)
				book_vals[e][f] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_codebook();
		test_codebook_fill();
		test_extremes();
		test_saturation();
		test_random();
		test_backpressure();
		wait_idle();

		if (error_count == 0 && exp_wr_ptr == exp_rd_ptr)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
